[src/rslm_pkg.sv]
// Package for the range scan local minimum finder.
// Holds sizes, register indexes and the result type; no dependencies.
package rslm_pkg;

    localparam int MAX_SAMPLES = 512;
    localparam int MAX_TARGETS = 16;

    localparam int WIN_LEN = 7;
    localparam int WIN_MID = 3;

    localparam int DIST_W  = 13;
    localparam int ANGLE_W = 12;
    localparam int STEP_W  = 6;
    localparam int SEP_W   = 12;
    localparam int ORD_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int IDX_W   = $clog2(MAX_SAMPLES + 1);
    localparam int FOUND_W = $clog2(MAX_TARGETS + 1);
    localparam int PROD_W  = (IDX_W + STEP_W > ANGLE_W + 1) ? IDX_W + STEP_W : ANGLE_W + 1;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_STEP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEPARATION = 2'd2;

    localparam logic [STEP_W-1:0] SCAN_STEP_RESET      = 6'd1;
    localparam logic [DIST_W-1:0] DISTANCE_LIMIT_RESET = 13'd500;
    localparam logic [SEP_W-1:0]  MIN_SEPARATION_RESET = 12'd20;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]  distance;
        logic [ORD_W-1:0]   ordinal;
    } rslm_result_t;

endpackage

[src/rslm_cell.sv]
// One tap of the sample window: holds a sample and compares it with the candidate.
// Depends on rslm_pkg.
module rslm_cell
    import rslm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              clear,
    input  logic              shift,
    input  logic [DIST_W-1:0] shift_in,
    input  logic [DIST_W-1:0] candidate,
    output logic [DIST_W-1:0] value_eff,
    output logic [DIST_W-1:0] value_next,
    output logic              cand_le
);

    logic [DIST_W-1:0] value_reg;

    assign value_eff  = clear ? '0 : value_reg;
    assign value_next = shift ? shift_in : value_eff;
    assign cand_le    = (candidate <= value_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (load)
        begin
            value_reg <= value_next;
        end
    end

endmodule

[src/rslm_out_buf.sv]
// Two-entry output buffer: a result register and a skid register behind it.
// Depends on rslm_pkg.
module rslm_out_buf
    import rslm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  rslm_result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  logic         out_stall,
    output rslm_result_t out_data
);

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    rslm_result_t out_data_reg, out_data_next;
    rslm_result_t skid_data_reg, skid_data_next;
    logic         pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            out_valid_next  = skid_valid_reg || push;
            out_data_next   = skid_valid_reg ? skid_data_reg : push_data;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

[src/range_scan_local_minimum_finder_unit.sv]
// Top level of the range scan local minimum finder: configuration, scan control,
// the row of window cells and the output buffer. Depends on rslm_pkg, rslm_cell
// and rslm_out_buf.
//
//   Channel  Direction  Handshake            Payload
//   in       sink       in_valid / in_stall  distance_mm, start_scan
//   out      source     out_valid/out_stall  target_angle, target_distance, target_ordinal
//   cfg      sink       cfg_write            cfg_index, cfg_data
//
// One request is taken every cycle while in_stall is low; its result, if any, is registered
// in the output or skid register, after a combinational compare across the seven cells.
// Reset clears the window, the counters and the output buffer and loads the
// register defaults. A two-entry output buffer lets requests flow while one result
// waits; in_stall rises only once a second result is waiting.
module range_scan_local_minimum_finder_unit
    import rslm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [DIST_W-1:0]     distance_mm,
    input  logic                  start_scan,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ANGLE_W-1:0]    target_angle,
    output logic [DIST_W-1:0]     target_distance,
    output logic [ORD_W-1:0]      target_ordinal
);

    logic [STEP_W-1:0]  scan_step_reg;
    logic [DIST_W-1:0]  distance_limit_reg;
    logic [SEP_W-1:0]   min_separation_reg;
    logic [IDX_W-1:0]   sample_index_reg, sample_index_next;
    logic [ANGLE_W-1:0] last_angle_reg, last_angle_next;
    logic [FOUND_W-1:0] found_reg, found_next;

    logic               accept;
    logic               buf_full;
    logic               room;
    logic [IDX_W-1:0]   idx_eff;
    logic [ANGLE_W-1:0] last_eff;
    logic [FOUND_W-1:0] found_eff;
    logic [IDX_W-1:0]   offset;
    logic [PROD_W-1:0]  product;
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W:0]   gap;
    logic               is_min;
    logic               spaced;
    logic               hit;
    rslm_result_t       result;
    rslm_result_t       out_data;

    logic [DIST_W-1:0]  cell_eff [WIN_LEN];
    logic [DIST_W-1:0]  cell_next [WIN_LEN];
    logic [WIN_LEN-1:0] cell_le;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_step_reg      <= SCAN_STEP_RESET;
            distance_limit_reg <= DISTANCE_LIMIT_RESET;
            min_separation_reg <= MIN_SEPARATION_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SCAN_STEP:      scan_step_reg      <= cfg_data[STEP_W-1:0];
                CFG_DISTANCE_LIMIT: distance_limit_reg <= cfg_data[DIST_W-1:0];
                CFG_MIN_SEPARATION: min_separation_reg <= cfg_data[SEP_W-1:0];
                default:            ;
            endcase
        end
    end

    assign idx_eff   = start_scan ? '0 : sample_index_reg;
    assign last_eff  = start_scan ? '0 : last_angle_reg;
    assign found_eff = start_scan ? '0 : found_reg;
    assign room      = (idx_eff < IDX_W'(MAX_SAMPLES));

    for (genvar i = 0; i < WIN_LEN; i++)
    begin : g_cell
        logic [DIST_W-1:0] shift_in;
        if (i == WIN_LEN - 1)
        begin : g_last
            assign shift_in = distance_mm;
        end
        else
        begin : g_inner
            assign shift_in = cell_eff[i + 1];
        end
        rslm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (accept),
            .clear      (start_scan),
            .shift      (room),
            .shift_in   (shift_in),
            .candidate  (cell_next[WIN_MID]),
            .value_eff  (cell_eff[i]),
            .value_next (cell_next[i]),
            .cand_le    (cell_le[i])
        );
    end

    assign offset  = idx_eff - IDX_W'(WIN_MID);
    assign product = PROD_W'(offset) * PROD_W'(scan_step_reg);
    assign angle   = (product > PROD_W'(ANGLE_MAX)) ? ANGLE_MAX : product[ANGLE_W-1:0];
    assign gap     = {1'b0, angle} - {1'b0, last_eff};

    assign is_min = (cell_next[WIN_MID] < distance_limit_reg) && (&cell_le);
    assign spaced = (found_eff == '0)
                    || ((angle > last_eff) && (gap[ANGLE_W-1:0] > min_separation_reg));
    assign hit    = room && (idx_eff >= IDX_W'(WIN_LEN - 1)) && is_min
                    && (found_eff < FOUND_W'(MAX_TARGETS)) && spaced;

    always_comb
    begin
        result.angle    = angle;
        result.distance = cell_next[WIN_MID];
        result.ordinal  = ORD_W'(found_eff);
    end

    always_comb
    begin
        sample_index_next = room ? idx_eff + IDX_W'(1) : idx_eff;
        last_angle_next   = hit ? angle : last_eff;
        found_next        = hit ? found_eff + FOUND_W'(1) : found_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            last_angle_reg   <= '0;
            found_reg        <= '0;
        end
        else if (accept)
        begin
            sample_index_reg <= sample_index_next;
            last_angle_reg   <= last_angle_next;
            found_reg        <= found_next;
        end
    end

    rslm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && hit),
        .push_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign target_angle    = out_data.angle;
    assign target_distance = out_data.distance;
    assign target_ordinal  = out_data.ordinal;

endmodule

[src/rslm_checker.sv]
// Port-level checks for the range scan local minimum finder, bound to its top level.
// Depends on rslm_pkg and range_scan_local_minimum_finder_unit.
module rslm_checker
    import rslm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_write,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic [DIST_W-1:0]     distance_mm,
    input logic                  start_scan,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [ANGLE_W-1:0]    target_angle,
    input logic [DIST_W-1:0]     target_distance,
    input logic [ORD_W-1:0]      target_ordinal
);

    // The input side is held back only while results are waiting.
    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall high with no result waiting");

    // The input side becomes stalled only after a result was held at the output.
    a_stall_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("in_stall rose without a held result");

    // A new result is always caused by a request taken in the previous cycle.
    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result appeared without an accepted request");

    // A held result keeps its fields.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(target_angle)
            && $stable(target_distance) && $stable(target_ordinal))
        else $error("held result changed");

endmodule

bind range_scan_local_minimum_finder_unit rslm_checker u_rslm_checker (.*);

[tb/sv/tb_range_scan_local_minimum_finder_unit.sv]
// Self-checking testbench for range_scan_local_minimum_finder_unit.
// Drives scans of range samples, predicts the reported targets on its own and checks each
// report field by field. Depends on rslm_pkg and the unit under test.
module tb_range_scan_local_minimum_finder_unit;
    import rslm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int ITEM_TARGET = 950;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              start;
    } range_req_t;

    typedef enum logic [1:0] {SHAPE_NOISE, SHAPE_VALLEY, SHAPE_PLATEAU} scan_shape_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_SCAN_STEP;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [DIST_W-1:0]     distance_mm = '0;
    logic                  start_scan = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [ANGLE_W-1:0]    target_angle;
    logic [DIST_W-1:0]     target_distance;
    logic [ORD_W-1:0]      target_ordinal;

    range_req_t   range_backlog[$];
    rslm_result_t due_targets[$];

    logic [STEP_W-1:0]  step_cfg = SCAN_STEP_RESET;
    logic [DIST_W-1:0]  limit_cfg = DISTANCE_LIMIT_RESET;
    logic [SEP_W-1:0]   sep_cfg = MIN_SEPARATION_RESET;
    logic [DIST_W-1:0]  range_win [WIN_LEN];
    logic [IDX_W-1:0]   range_count = '0;
    logic [ANGLE_W-1:0] last_angle = '0;
    logic [FOUND_W-1:0] found_count = '0;

    int mismatches = 0;
    int items_queued = 0;
    int quiet_cycles = 0;
    int send_gap = 0;
    int stall_left = 0;
    int free_left = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    bit steady_sender = 1'b0;
    bit steady_receiver = 1'b0;
    range_req_t next_req;

    range_scan_local_minimum_finder_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .distance_mm     (distance_mm),
        .start_scan      (start_scan),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .target_angle    (target_angle),
        .target_distance (target_distance),
        .target_ordinal  (target_ordinal)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        for (int t = 0; t < WIN_LEN; t++)
        begin
            range_win[t] = '0;
        end
    end

    function automatic void find_target(logic [DIST_W-1:0] range_mm, logic fresh);
        int unsigned  angle;
        int           k;
        logic [DIST_W-1:0] center;
        rslm_result_t hit;
        if (fresh)
        begin
            for (int t = 0; t < WIN_LEN; t++)
            begin
                range_win[t] = '0;
            end
            range_count = '0;
            last_angle = '0;
            found_count = '0;
        end
        if (range_count >= MAX_SAMPLES)
        begin
            return;
        end
        for (int t = 0; t < WIN_LEN - 1; t++)
        begin
            range_win[t] = range_win[t + 1];
        end
        range_win[WIN_LEN - 1] = range_mm;
        k = range_count;
        range_count = range_count + 1'b1;
        if (k < WIN_LEN - 1)
        begin
            return;
        end
        center = range_win[WIN_MID];
        if (center >= limit_cfg)
        begin
            return;
        end
        for (int t = 0; t < WIN_LEN; t++)
        begin
            if (center > range_win[t])
            begin
                return;
            end
        end
        if (found_count >= MAX_TARGETS)
        begin
            return;
        end
        angle = (k - WIN_MID) * step_cfg;
        if (angle > ANGLE_MAX)
        begin
            angle = ANGLE_MAX;
        end
        if (found_count != 0)
        begin
            if (angle <= last_angle)
            begin
                return;
            end
            if (angle - last_angle <= sep_cfg)
            begin
                return;
            end
        end
        hit.angle = angle[ANGLE_W-1:0];
        hit.distance = center;
        hit.ordinal = found_count[ORD_W-1:0];
        due_targets.push_back(hit);
        last_angle = angle[ANGLE_W-1:0];
        found_count = found_count + 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Request side: one request is offered at a time and held until it is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                find_target(distance_mm, start_scan);
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (range_backlog.size() > 0)
                begin
                    next_req = range_backlog.pop_front();
                    in_valid <= 1'b1;
                    distance_mm <= next_req.distance;
                    start_scan <= next_req.start;
                    send_gap = steady_sender ? 0 : pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (due_targets.size() == 0)
                begin
                    $display("%0t: unexpected target angle %0d distance %0d ordinal %0d",
                             $time, target_angle, target_distance, target_ordinal);
                    mismatches++;
                end
                else
                begin
                    if (target_angle !== due_targets[0].angle)
                    begin
                        $display("%0t: target_angle expected %0d actual %0d",
                                 $time, due_targets[0].angle, target_angle);
                        mismatches++;
                    end
                    if (target_distance !== due_targets[0].distance)
                    begin
                        $display("%0t: target_distance expected %0d actual %0d",
                                 $time, due_targets[0].distance, target_distance);
                        mismatches++;
                    end
                    if (target_ordinal !== due_targets[0].ordinal)
                    begin
                        $display("%0t: target_ordinal expected %0d actual %0d",
                                 $time, due_targets[0].ordinal, target_ordinal);
                        mismatches++;
                    end
                    void'(due_targets.pop_front());
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (steady_receiver)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                if (stall_left == 0 && free_left == 0)
                begin
                    stall_left = pick_gap();
                    free_left = $urandom_range(1, 8);
                end
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_stall <= 1'b1;
                end
                else
                begin
                    free_left--;
                    out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("range_scan_local_minimum_finder_unit test failed");
        $finish;
    end

    task automatic queue_range(input int range_mm, input bit fresh);
        range_req_t req;
        req.distance = range_mm[DIST_W-1:0];
        req.start = fresh;
        range_backlog.push_back(req);
        items_queued++;
    endtask

    task automatic queue_scan(input int len, input scan_shape_t shape, input bit fresh,
                              input int base);
        int range_mm;
        bit mark;
        for (int t = 0; t < len; t++)
        begin
            case (shape)
                SHAPE_VALLEY:
                begin
                    range_mm = ($urandom_range(0, 4) == 0) ? $urandom_range(0, base)
                                                          : $urandom_range(0, 8191);
                end
                SHAPE_PLATEAU:
                begin
                    range_mm = ($urandom_range(0, 9) == 0) ? (base ^ 1) : base;
                end
                default:
                begin
                    range_mm = $urandom_range(0, 8191);
                end
            endcase
            if (t == 0)
            begin
                mark = fresh;
            end
            else
            begin
                mark = (shape == SHAPE_NOISE) && ($urandom_range(0, 15) == 0);
            end
            queue_range(range_mm, mark);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_SCAN_STEP:      step_cfg = val[STEP_W-1:0];
            CFG_DISTANCE_LIMIT: limit_cfg = val[DIST_W-1:0];
            CFG_MIN_SEPARATION: sep_cfg = val[SEP_W-1:0];
            default:            ;
        endcase
    endtask

    task automatic set_regs(input int step, input int limit, input int sep);
        write_reg(CFG_SCAN_STEP, step);
        write_reg(CFG_DISTANCE_LIMIT, limit);
        write_reg(CFG_MIN_SEPARATION, sep);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        while (range_backlog.size() != 0 || in_valid || due_targets.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic int pick_step();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 1;
            2:       return 63;
            default: return $urandom_range(1, 45);
        endcase
    endfunction

    function automatic int pick_limit();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 8191;
            2:       return 500;
            default: return $urandom_range(200, 8191);
        endcase
    endfunction

    function automatic int pick_sep();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 4095;
            2:       return 20;
            default: return $urandom_range(0, 100);
        endcase
    endfunction

    initial
    begin
        int          opening [24];
        int          limit;
        scan_shape_t shape;
        opening = '{8191, 8191, 700, 499, 600, 8191, 8191, 8191, 0, 8191, 8191, 8191,
                    500, 8191, 8191, 8191, 300, 300, 300, 300, 300, 300, 300, 300};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The first scan runs from reset with no start mark.
        for (int t = 0; t < 24; t++)
        begin
            queue_range(opening[t], t == 16);
        end
        settle();

        set_regs(0, 8191, 4095);
        queue_scan(30, SHAPE_PLATEAU, 1'b1, 100);
        settle();

        set_regs(45, 8191, 0);
        queue_scan(110, SHAPE_VALLEY, 1'b1, 8191);
        settle();

        // Many targets back to back while the receiver holds off.
        set_regs(1, 8191, 0);
        steady_sender = 1'b1;
        repeat (3)
        begin
            queue_scan(40, SHAPE_PLATEAU, 1'b1, $urandom_range(0, 8190));
        end
        hold_req = 1'b1;
        settle();
        steady_sender = 1'b0;

        set_regs(10, 8191, 0);
        queue_scan(40, SHAPE_VALLEY, 1'b1, 3000);
        settle();
        set_regs(1, 8191, 0);
        queue_scan(30, SHAPE_VALLEY, 1'b0, 3000);
        settle();

        set_regs(1, 2000, 5);
        queue_scan(520, SHAPE_VALLEY, 1'b1, 2000);
        settle();

        while (items_queued < ITEM_TARGET)
        begin
            limit = pick_limit();
            set_regs(pick_step(), limit, pick_sep());
            steady_sender = ($urandom_range(0, 3) == 0);
            steady_receiver = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3))
            begin
                shape = scan_shape_t'($urandom_range(0, 2));
                queue_scan($urandom_range(8, 60), shape, $urandom_range(0, 7) != 0,
                           (limit > 0) ? limit - 1 : 0);
            end
            settle();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("range_scan_local_minimum_finder_unit test passed");
        end
        else
        begin
            $display("range_scan_local_minimum_finder_unit test failed");
        end
        $finish;
    end

endmodule
